### rtl/core/kmhcf_pkg.sv
`default_nettype none

package kmhcf_pkg;

	// Fixed field widths of the request and result channels
	localparam int SLOT_IN_W   = 11;
	localparam int OFFSET_IN_W = 16;
	localparam int COUNT_W     = 16;
	localparam int CAND_W      = 10;
	localparam int FWD_W       = 11;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Operation codes
	localparam logic OP_HIT    = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_COUNT     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPAN      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_COUNT = 2'd2;

	// Reset values of the configuration registers
	localparam logic [CFG_DATA_W-1:0] MIN_COUNT_RST     = 16'd1;
	localparam logic [CFG_DATA_W-1:0] MIN_SPAN_RST      = 16'd0;
	localparam logic [FWD_W-1:0]      FORWARD_COUNT_RST = 11'd1024;

	typedef struct packed {
		logic                   op;
		logic [SLOT_IN_W-1:0]   matched_slot;
		logic [OFFSET_IN_W-1:0] query_offset;
	} in_item_t;

	typedef struct packed {
		logic [CAND_W-1:0] candidate;
		logic              none_found;
		logic              last;
		logic              overflow;
	} out_item_t;

	// Slot table access strobes
	typedef struct packed {
		logic rd;
		logic wr;
	} slot_ctrl_t;

	// Match list control strobes
	typedef struct packed {
		logic rd;
		logic append;
		logic set_ovf;
		logic clear;
	} list_ctrl_t;

	// Match list status
	typedef struct packed {
		logic full;
		logic overflow;
	} list_stat_t;

endpackage

`default_nettype wire

### rtl/core/kmhcf_slot_mem.sv
`default_nettype none

module kmhcf_slot_mem #(
	parameter int NUM_SLOTS = 2048,
	parameter int WORD_W    = 48
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire kmhcf_pkg::slot_ctrl_t         ctrl,
	input  wire logic [$clog2(NUM_SLOTS)-1:0]  rd_addr,
	input  wire logic [$clog2(NUM_SLOTS)-1:0]  wr_addr,
	input  wire logic [WORD_W-1:0]             wr_data,
	output logic      [WORD_W-1:0]             rd_data,
	output logic                               clr_busy
);

	localparam int SLOT_W = $clog2(NUM_SLOTS);

	logic [WORD_W-1:0] mem [NUM_SLOTS];
	logic [WORD_W-1:0] rd_data_q;
	logic [SLOT_W-1:0] clr_addr_q;
	logic              clr_busy_q;
	logic              we;
	logic [SLOT_W-1:0] wa;
	logic [WORD_W-1:0] wd;

	// Sweep every slot to a zero count after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == SLOT_W'(NUM_SLOTS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Steer the write port to the clearing sweep while it runs
	always_comb begin
		we = clr_busy_q | ctrl.wr;
		wa = clr_busy_q ? clr_addr_q : wr_addr;
		wd = clr_busy_q ? '0 : wr_data;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.rd) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data  = rd_data_q;
	assign clr_busy = clr_busy_q;

endmodule

`default_nettype wire

### rtl/core/kmhcf_list.sv
`default_nettype none

module kmhcf_list #(
	parameter int MATCH_LIST_DEPTH = 64
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire kmhcf_pkg::list_ctrl_t                   ctrl,
	input  wire logic [kmhcf_pkg::SLOT_IN_W-1:0]         wr_slot,
	input  wire logic [((MATCH_LIST_DEPTH > 1) ? $clog2(MATCH_LIST_DEPTH) : 1)-1:0] rd_idx,
	output logic      [kmhcf_pkg::SLOT_IN_W-1:0]         rd_slot,
	output logic      [$clog2(MATCH_LIST_DEPTH + 1)-1:0] len,
	output kmhcf_pkg::list_stat_t                        stat
);

	localparam int LEN_W = $clog2(MATCH_LIST_DEPTH + 1);
	localparam int IDX_W = (MATCH_LIST_DEPTH > 1) ? $clog2(MATCH_LIST_DEPTH) : 1;

	logic [kmhcf_pkg::SLOT_IN_W-1:0] list_mem [MATCH_LIST_DEPTH];
	logic [kmhcf_pkg::SLOT_IN_W-1:0] rd_slot_q;
	logic [LEN_W-1:0]                len_q;
	logic                            ovf_q;

	// Track fill level and dropped-slot flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			ovf_q <= 1'b0;
		end else if (ctrl.clear) begin
			len_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			if (ctrl.append) begin
				len_q <= len_q + 1'b1;
			end
			if (ctrl.set_ovf) begin
				ovf_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.append) begin
			list_mem[len_q[IDX_W-1:0]] <= wr_slot;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.rd) begin
			rd_slot_q <= list_mem[rd_idx];
		end
	end

	assign rd_slot       = rd_slot_q;
	assign len           = len_q;
	assign stat.full     = (len_q == LEN_W'(MATCH_LIST_DEPTH));
	assign stat.overflow = ovf_q;

`ifndef SYNTHESIS
	a_no_append_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.append |-> (len_q < LEN_W'(MATCH_LIST_DEPTH)))
		else $error("append to a full match list");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.clear |=> (len_q == '0) && !ovf_q)
		else $error("match list not emptied by clear");
`endif

endmodule

`default_nettype wire

### rtl/core/kmhcf_mod_unit.sv
`default_nettype none

module kmhcf_mod_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [kmhcf_pkg::SLOT_IN_W-1:0] dividend,
	input  wire logic [kmhcf_pkg::FWD_W-1:0]     divisor,
	output logic                                 busy,
	output logic      [kmhcf_pkg::SLOT_IN_W-1:0] remainder
);

	localparam int DW    = kmhcf_pkg::SLOT_IN_W;
	localparam int CNT_W = $clog2(DW + 1);

	logic [DW:0]                     rem_q;
	logic [DW-1:0]                   dvd_q;
	logic [kmhcf_pkg::FWD_W-1:0]     div_q;
	logic [CNT_W-1:0]                cnt_q;
	logic                            busy_q;
	logic [DW:0]                     trial;
	logic                            fits;

	// One restoring step: shift in a dividend bit, subtract when it fits
	always_comb begin
		trial = {rem_q[DW-1:0], dvd_q[DW-1]};
		fits  = (trial >= (DW + 1)'(div_q));
	end

	// Count steps; a zero divisor passes the dividend straight through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= (divisor != '0);
			cnt_q  <= CNT_W'(DW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			dvd_q <= dividend;
			rem_q <= (divisor == '0) ? (DW + 1)'(dividend) : '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DW-2:0], 1'b0};
			rem_q <= fits ? (trial - (DW + 1)'(div_q)) : trial;
		end
	end

	assign busy      = busy_q;
	assign remainder = rem_q[DW-1:0];

endmodule

`default_nettype wire

### rtl/core/kmer_hit_candidate_filter.sv
// Shared-word hit filter for one query. A hit request (op 0) passes through
// accept, slot table read and read-modify-write of the slot's count and offsets; a
// hit to a slot at or above NUM_SLOTS ends at its accept. A finish request (op 1)
// passes through its accept, then for each listed slot a list read, a slot table
// read and a clear-and-evaluate step; a slot that passes then waits on the
// bit-serial modulo unit (one quotient bit per cycle over 11 bits; no division
// when forward_count is zero) before its push. A final list check and an end
// step close the run, and any output stall holds it. Every finish gives at
// least one result; the final one has last set, and a run with no passing slot
// gives a single none_found result.
// The slot table has a single read and a single write port. After reset it is
// swept to zero counts; requests stall meanwhile, configuration writes are taken.
`default_nettype none

module kmer_hit_candidate_filter #(
	parameter int NUM_SLOTS        = 2048,
	parameter int MATCH_LIST_DEPTH = 64,
	parameter int OFFSET_BITS      = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire kmhcf_pkg::in_item_t              in_item,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output kmhcf_pkg::out_item_t                  out_item,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [kmhcf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [kmhcf_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int SLOT_W = $clog2(NUM_SLOTS);
	localparam int LEN_W  = $clog2(MATCH_LIST_DEPTH + 1);
	localparam int IDX_W  = (MATCH_LIST_DEPTH > 1) ? $clog2(MATCH_LIST_DEPTH) : 1;
	localparam int CW     = kmhcf_pkg::COUNT_W;
	localparam int WORD_W = CW + 2 * OFFSET_BITS;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_HIT_RD   = 4'd1;
	localparam logic [3:0] S_HIT_WR   = 4'd2;
	localparam logic [3:0] S_FIN_LIST = 4'd3;
	localparam logic [3:0] S_FIN_SLOT = 4'd4;
	localparam logic [3:0] S_FIN_EVAL = 4'd5;
	localparam logic [3:0] S_FIN_MOD  = 4'd6;
	localparam logic [3:0] S_FIN_PUSH = 4'd7;
	localparam logic [3:0] S_FIN_END  = 4'd8;

	logic [3:0]                        state_q, state_d;
	kmhcf_pkg::in_item_t               item_q, item_d;
	logic [kmhcf_pkg::SLOT_IN_W-1:0]   cur_slot_q, cur_slot_d;
	logic [LEN_W-1:0]                  r_q, r_d;
	logic                              pend_q, pend_d;
	logic [kmhcf_pkg::CAND_W-1:0]      pend_cand_q, pend_cand_d;
	kmhcf_pkg::out_item_t              out_q, out_d;
	logic                              out_valid_q, out_valid_d;
	logic                              out_load;

	logic [CW-1:0]                     min_count_q;
	logic [CW-1:0]                     min_span_q;
	logic [kmhcf_pkg::FWD_W-1:0]       fwd_count_q;

	kmhcf_pkg::slot_ctrl_t             slot_ctrl;
	logic [SLOT_W-1:0]                 slot_rd_addr, slot_wr_addr;
	logic [WORD_W-1:0]                 slot_wdata, slot_rdata;
	logic                              clr_busy;

	kmhcf_pkg::list_ctrl_t             list_ctrl;
	logic [kmhcf_pkg::SLOT_IN_W-1:0]   list_rd_slot;
	logic [LEN_W-1:0]                  list_len;
	kmhcf_pkg::list_stat_t             list_stat;

	logic                              mod_start, mod_busy;
	logic [kmhcf_pkg::SLOT_IN_W-1:0]   mod_rem;

	logic                              in_acc, out_free, in_range;
	logic [CW-1:0]                     rd_count;
	logic [OFFSET_BITS-1:0]            rd_first, rd_last, offs, span;
	logic                              pass;

	kmhcf_slot_mem #(
		.NUM_SLOTS (NUM_SLOTS),
		.WORD_W    (WORD_W)
	) u_slot_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (slot_ctrl),
		.rd_addr  (slot_rd_addr),
		.wr_addr  (slot_wr_addr),
		.wr_data  (slot_wdata),
		.rd_data  (slot_rdata),
		.clr_busy (clr_busy)
	);

	kmhcf_list #(
		.MATCH_LIST_DEPTH (MATCH_LIST_DEPTH)
	) u_list (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (list_ctrl),
		.wr_slot (item_q.matched_slot),
		.rd_idx  (r_q[IDX_W-1:0]),
		.rd_slot (list_rd_slot),
		.len     (list_len),
		.stat    (list_stat)
	);

	kmhcf_mod_unit u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (cur_slot_q),
		.divisor   (fwd_count_q),
		.busy      (mod_busy),
		.remainder (mod_rem)
	);

	// Take configuration writes at any time
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_count_q <= kmhcf_pkg::MIN_COUNT_RST;
			min_span_q  <= kmhcf_pkg::MIN_SPAN_RST;
			fwd_count_q <= kmhcf_pkg::FORWARD_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				kmhcf_pkg::CFG_MIN_COUNT: begin
					min_count_q <= cfg_data;
				end
				kmhcf_pkg::CFG_MIN_SPAN: begin
					min_span_q <= cfg_data;
				end
				kmhcf_pkg::CFG_FORWARD_COUNT: begin
					fwd_count_q <= cfg_data[kmhcf_pkg::FWD_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Handshake and field decode
	assign in_stall = !((state_q == S_IDLE) && !clr_busy);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign in_range = (32'(in_item.matched_slot) < 32'(NUM_SLOTS));

	assign {rd_count, rd_first, rd_last} = slot_rdata;
	assign offs = OFFSET_BITS'(item_q.query_offset);
	assign span = rd_last - rd_first;
	assign pass = (rd_count >= min_count_q) && (rd_last >= rd_first) &&
		(32'(span) >= 32'(min_span_q));

	// Sequence hit and finish requests
	always_comb begin
		state_d      = state_q;
		item_d       = item_q;
		cur_slot_d   = cur_slot_q;
		r_d          = r_q;
		pend_d       = pend_q;
		pend_cand_d  = pend_cand_q;
		out_d        = out_q;
		out_load     = 1'b0;
		slot_ctrl    = '0;
		list_ctrl    = '0;
		mod_start    = 1'b0;
		slot_rd_addr = SLOT_W'(item_q.matched_slot);
		slot_wr_addr = SLOT_W'(item_q.matched_slot);
		slot_wdata   = {rd_count, rd_first, offs};

		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					item_d = in_item;
					r_d    = '0;
					if (in_item.op == kmhcf_pkg::OP_FINISH) begin
						state_d = S_FIN_LIST;
					end else if (in_range) begin
						state_d = S_HIT_RD;
					end
				end
			end
			S_HIT_RD: begin
				slot_ctrl.rd = 1'b1;
				state_d      = S_HIT_WR;
			end
			S_HIT_WR: begin
				if (rd_count == '0) begin
					// First hit: open the slot, or drop it when the list is full
					if (list_stat.full) begin
						list_ctrl.set_ovf = 1'b1;
					end else begin
						slot_ctrl.wr     = 1'b1;
						slot_wdata       = {CW'(1), offs, offs};
						list_ctrl.append = 1'b1;
					end
				end else begin
					slot_ctrl.wr = 1'b1;
					slot_wdata   = {(rd_count == kmhcf_pkg::COUNT_MAX) ? rd_count :
						rd_count + 1'b1, rd_first, offs};
				end
				state_d = S_IDLE;
			end
			S_FIN_LIST: begin
				if (r_q == list_len) begin
					state_d = S_FIN_END;
				end else begin
					list_ctrl.rd = 1'b1;
					state_d      = S_FIN_SLOT;
				end
			end
			S_FIN_SLOT: begin
				slot_ctrl.rd = 1'b1;
				slot_rd_addr = SLOT_W'(list_rd_slot);
				cur_slot_d   = list_rd_slot;
				state_d      = S_FIN_EVAL;
			end
			S_FIN_EVAL: begin
				// Clear the slot and reduce it if it passes
				slot_ctrl.wr = 1'b1;
				slot_wr_addr = SLOT_W'(cur_slot_q);
				slot_wdata   = {CW'(0), rd_first, rd_last};
				if (pass) begin
					mod_start = 1'b1;
					state_d   = S_FIN_MOD;
				end else begin
					r_d     = r_q + 1'b1;
					state_d = S_FIN_LIST;
				end
			end
			S_FIN_MOD: begin
				if (!mod_busy) begin
					state_d = S_FIN_PUSH;
				end
			end
			S_FIN_PUSH: begin
				// Hold the newest candidate back until it is known not to be last
				if (!pend_q) begin
					pend_d      = 1'b1;
					pend_cand_d = mod_rem[kmhcf_pkg::CAND_W-1:0];
					r_d         = r_q + 1'b1;
					state_d     = S_FIN_LIST;
				end else if (out_free) begin
					out_load         = 1'b1;
					out_d.candidate  = pend_cand_q;
					out_d.none_found = 1'b0;
					out_d.last       = 1'b0;
					out_d.overflow   = list_stat.overflow;
					pend_cand_d      = mod_rem[kmhcf_pkg::CAND_W-1:0];
					r_d              = r_q + 1'b1;
					state_d          = S_FIN_LIST;
				end
			end
			S_FIN_END: begin
				if (out_free) begin
					out_load         = 1'b1;
					out_d.candidate  = pend_q ? pend_cand_q : '0;
					out_d.none_found = !pend_q;
					out_d.last       = 1'b1;
					out_d.overflow   = list_stat.overflow;
					pend_d           = 1'b0;
					list_ctrl.clear  = 1'b1;
					state_d          = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign out_valid_d = out_load | (out_valid_q & out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			r_q         <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			r_q         <= r_d;
			pend_q      <= pend_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		item_q      <= item_d;
		cur_slot_q  <= cur_slot_d;
		pend_cand_q <= pend_cand_d;
		out_q       <= out_d;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

`ifndef SYNTHESIS
	a_end_gives_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN_END) && out_free |=> out_valid && out_item.last)
		else $error("finish run closed without a last result");

	a_none_found_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.none_found |-> out_item.last && (out_item.candidate == '0))
		else $error("none_found result malformed");

	a_mod_in_mod_state: assert property (@(posedge clk) disable iff (!arst_n)
		mod_busy |-> (state_q == S_FIN_MOD))
		else $error("modulo unit busy outside its wait state");

	a_no_pending_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_q)
		else $error("candidate left pending after a finish run");
`endif

endmodule

`default_nettype wire

### test/kmer_hit_candidate_filter_tb.sv
`timescale 1ns / 100ps
`default_nettype none

module kmer_hit_candidate_filter_tb;

	localparam int NUM_SLOTS    = 2048;
	localparam int LIST_DEPTH   = 64;
	localparam int OFFSET_BITS  = 16;
	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int SETTLE_TIME  = 16;
	localparam int PHASE_BUDGET = 45;
	localparam int LONG_HOLD    = 800;

	// Index past the register list; writes to it must be ignored
	localparam logic [kmhcf_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	// Shadow of the hit table and match list; predicts the candidates of each finish
	class hit_filter_scoreboard;
		bit [kmhcf_pkg::COUNT_W-1:0]     hit_tally [NUM_SLOTS];
		bit [kmhcf_pkg::OFFSET_IN_W-1:0] first_offs [NUM_SLOTS];
		bit [kmhcf_pkg::OFFSET_IN_W-1:0] last_offs [NUM_SLOTS];
		bit                              slot_seen [NUM_SLOTS];
		bit [kmhcf_pkg::SLOT_IN_W-1:0]   listed_slots [$];
		bit                              dropped;
		bit [kmhcf_pkg::CFG_DATA_W-1:0]  min_count;
		bit [kmhcf_pkg::CFG_DATA_W-1:0]  min_span;
		bit [kmhcf_pkg::FWD_W-1:0]       fwd_count;
		kmhcf_pkg::out_item_t            expected_candidates [$];
		int                              errors;

		function new();
			min_count = kmhcf_pkg::MIN_COUNT_RST;
			min_span  = kmhcf_pkg::MIN_SPAN_RST;
			fwd_count = kmhcf_pkg::FORWARD_COUNT_RST;
			dropped   = 1'b0;
			errors    = 0;
		endfunction

		function void write_reg(bit [kmhcf_pkg::CFG_IDX_W-1:0] idx,
				bit [kmhcf_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				kmhcf_pkg::CFG_MIN_COUNT:     min_count = data;
				kmhcf_pkg::CFG_MIN_SPAN:      min_span = data;
				kmhcf_pkg::CFG_FORWARD_COUNT: fwd_count = data[kmhcf_pkg::FWD_W-1:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_candidates.size();
		endfunction

		// Apply one accepted request to the shadow state
		function void record_request(kmhcf_pkg::in_item_t req);
			bit [kmhcf_pkg::SLOT_IN_W-1:0]   slot;
			bit [kmhcf_pkg::OFFSET_IN_W-1:0] offs;
			bit [kmhcf_pkg::FWD_W-1:0]       cand;
			bit [kmhcf_pkg::FWD_W-1:0]       passed [$];
			kmhcf_pkg::out_item_t            res;
			slot = req.matched_slot;
			offs = req.query_offset;
			if (req.op == kmhcf_pkg::OP_HIT) begin
				if (!slot_seen[slot]) begin
					// drop a new slot once the list is full
					if (listed_slots.size() >= LIST_DEPTH) begin
						dropped = 1'b1;
						return;
					end
					listed_slots.push_back(slot);
					slot_seen[slot] = 1'b1;
					first_offs[slot] = offs;
				end
				last_offs[slot] = offs;
				if (hit_tally[slot] != kmhcf_pkg::COUNT_MAX)
					hit_tally[slot]++;
				return;
			end
			// walk the list, keep slots that pass both thresholds, clear every one
			foreach (listed_slots[i]) begin
				slot = listed_slots[i];
				if (hit_tally[slot] >= min_count && last_offs[slot] >= first_offs[slot] &&
						last_offs[slot] - first_offs[slot] >= min_span) begin
					cand = (fwd_count == 0) ? slot : slot % fwd_count;
					passed.push_back(cand);
				end
				hit_tally[slot] = '0;
				slot_seen[slot] = 1'b0;
			end
			if (passed.size() == 0) begin
				res = '{candidate: '0, none_found: 1'b1, last: 1'b1, overflow: dropped};
				expected_candidates.push_back(res);
			end
			foreach (passed[i]) begin
				res.candidate  = passed[i][kmhcf_pkg::CAND_W-1:0];
				res.none_found = 1'b0;
				res.last       = (i == passed.size() - 1);
				res.overflow   = dropped;
				expected_candidates.push_back(res);
			end
			listed_slots.delete();
			dropped = 1'b0;
		endfunction

		// Compare one accepted result with the oldest expectation
		function void check_candidate(kmhcf_pkg::out_item_t got);
			kmhcf_pkg::out_item_t want;
			if (expected_candidates.size() == 0) begin
				$display("%0t: unexpected result: expected none, got %p", $time, got);
				errors++;
				return;
			end
			want = expected_candidates.pop_front();
			if (got.candidate !== want.candidate) begin
				$display("%0t: candidate mismatch: expected %0d, got %0d",
					$time, want.candidate, got.candidate);
				errors++;
			end
			if (got.none_found !== want.none_found) begin
				$display("%0t: none_found mismatch: expected %0b, got %0b",
					$time, want.none_found, got.none_found);
				errors++;
			end
			if (got.last !== want.last) begin
				$display("%0t: last mismatch: expected %0b, got %0b",
					$time, want.last, got.last);
				errors++;
			end
			if (got.overflow !== want.overflow) begin
				$display("%0t: overflow mismatch: expected %0b, got %0b",
					$time, want.overflow, got.overflow);
				errors++;
			end
		endfunction
	endclass

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                in_valid = 1'b0;
	logic                                in_stall;
	kmhcf_pkg::in_item_t                 in_item = '0;
	logic                                out_valid;
	logic                                out_stall = 1'b0;
	kmhcf_pkg::out_item_t                out_item;
	logic                                cfg_valid = 1'b0;
	logic                                cfg_ready;
	logic [kmhcf_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
	logic [kmhcf_pkg::CFG_DATA_W-1:0]    cfg_data = '0;

	hit_filter_scoreboard sb;
	bit sender_idle = 1'b1;
	bit receiver_idle = 1'b1;
	int hold_cycles_req = 0;
	int stall_left = 0;
	int requests_sent = 0;
	int cycle_count = 0;

	kmer_hit_candidate_filter #(
		.NUM_SLOTS(NUM_SLOTS),
		.MATCH_LIST_DEPTH(LIST_DEPTH),
		.OFFSET_BITS(OFFSET_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Take results, check them, and draw the stall before the next one
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_candidate(out_item);
			stall_left = receiver_idle ? $urandom_range(0, 14) : 0;
		end
		if (hold_cycles_req != 0) begin
			stall_left = hold_cycles_req;
			hold_cycles_req = 0;
		end
		out_stall <= (stall_left != 0);
		if (stall_left != 0)
			stall_left--;
	end

	function automatic kmhcf_pkg::in_item_t hit_req(int slot, int offs);
		kmhcf_pkg::in_item_t req;
		req.op = kmhcf_pkg::OP_HIT;
		req.matched_slot = slot[kmhcf_pkg::SLOT_IN_W-1:0];
		req.query_offset = offs[kmhcf_pkg::OFFSET_IN_W-1:0];
		return req;
	endfunction

	// Finish request; the unused fields carry random content
	function automatic kmhcf_pkg::in_item_t finish_req();
		kmhcf_pkg::in_item_t req;
		int                  slot;
		int                  offs;
		slot = $urandom_range(0, NUM_SLOTS - 1);
		offs = $urandom_range(0, 65535);
		req.op = kmhcf_pkg::OP_FINISH;
		req.matched_slot = slot[kmhcf_pkg::SLOT_IN_W-1:0];
		req.query_offset = offs[kmhcf_pkg::OFFSET_IN_W-1:0];
		return req;
	endfunction

	// Offer one request and hold it until accepted
	task automatic send_request(input kmhcf_pkg::in_item_t req);
		int gap;
		gap = sender_idle ? $urandom_range(0, 14) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= req;
		do @(posedge clk); while (in_stall);
		sb.record_request(req);
		requests_sent++;
	endtask

	task automatic write_reg(input logic [kmhcf_pkg::CFG_IDX_W-1:0] idx,
			input logic [kmhcf_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Stop offering, wait out every expected result, then let in-flight hits settle
	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_TIME) @(posedge clk);
	endtask

	task automatic set_thresholds(input logic [15:0] mc, input logic [15:0] ms,
			input logic [15:0] fc);
		write_reg(kmhcf_pkg::CFG_MIN_COUNT, mc);
		write_reg(kmhcf_pkg::CFG_MIN_SPAN, ms);
		write_reg(kmhcf_pkg::CFG_FORWARD_COUNT, fc);
	endtask

	// One query: hits over a pool of slots with mostly rising offsets, then finish
	task automatic run_query(input bit wide);
		int n_slots;
		int n_hits;
		int offs;
		int slot;
		int pool [$];
		n_slots = wide ? $urandom_range(60, 80) : $urandom_range(1, 12);
		for (int i = 0; i < n_slots; i++)
			pool.push_back($urandom_range(0, NUM_SLOTS - 1));
		n_hits = wide ? n_slots + $urandom_range(0, 10) : $urandom_range(n_slots, 3 * n_slots);
		offs = $urandom_range(0, 65535);
		for (int i = 0; i < n_hits; i++) begin
			slot = (i < n_slots) ? pool[i] : pool[$urandom_range(0, n_slots - 1)];
			if ($urandom_range(0, 7) == 0)
				offs = $urandom_range(0, 65535);
			else
				offs = (offs + $urandom_range(0, 40)) % 65536;
			send_request(hit_req(slot, offs));
			// break the sequence now and then with an early finish
			if ($urandom_range(0, 19) == 0)
				send_request(finish_req());
		end
		send_request(finish_req());
	endtask

	initial begin
		int phase_start;
		int n_queries;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Program the reset values and poke the unused index
		set_thresholds(16'd1, 16'd0, 16'h0400);
		write_reg(CFG_UNUSED, 16'hFFFF);

		// Empty query, slot extremes, backward span, modulo wrap
		send_request(finish_req());
		send_request(hit_req(0, 0));
		send_request(hit_req(2047, 65535));
		send_request(hit_req(2047, 0));
		send_request(hit_req(1024, 5));
		send_request(hit_req(1024, 7));
		send_request(finish_req());
		drain_results();

		// Unreduced candidate masked to 10 bits; span and count thresholds
		set_thresholds(16'd2, 16'd2, 16'hF800);
		send_request(hit_req(1500, 100));
		send_request(hit_req(1500, 101));
		send_request(hit_req(1777, 10));
		send_request(hit_req(1777, 12));
		send_request(hit_req(3, 65535));
		send_request(finish_req());
		drain_results();

		// Modulus above the candidate range
		set_thresholds(16'd1, 16'd0, 16'd1025);
		send_request(hit_req(2047, 1));
		send_request(hit_req(1025, 2));
		send_request(hit_req(1025, 1));
		send_request(finish_req());
		drain_results();

		// Random phases, each under its own settings and idling pattern
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: set_thresholds(16'd1, 16'd0, 16'h0400);
				1: set_thresholds(16'd0, 16'd0, 16'h0001);
				2: set_thresholds(16'd3, 16'd20, 16'h0007);
				3: set_thresholds(16'hFFFF, 16'hFFFF, 16'h0000);
				4: set_thresholds(16'd2, 16'd0, 16'hFFFF);
				default: begin
					set_thresholds(16'($urandom_range(1, 3)), 16'($urandom_range(0, 300)),
						16'($urandom_range(0, 65535)));
					write_reg(CFG_UNUSED, 16'($urandom_range(0, 65535)));
				end
			endcase
			sender_idle = (p == 0 || p == 3 || p == 4);
			receiver_idle = (p != 1 && p != 4);
			// hold the result side off while requests keep coming
			if (p == 2)
				hold_cycles_req = LONG_HOLD;
			phase_start = requests_sent;
			n_queries = 0;
			while (requests_sent - phase_start < PHASE_BUDGET) begin
				run_query((n_queries == 0 && (p == 0 || p == 4)) ||
					$urandom_range(0, 15) == 0);
				n_queries++;
			end
			drain_results();
		end

		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire
